// ----- rtl/ljsp_pkg.sv -----
// Shared types and constants for the junction speed planner.
// No dependencies.
package ljsp_pkg;

   localparam int Blocks = 16;
   localparam int PtrW = $clog2(Blocks);
   localparam int SqW = 56;
   localparam int SpdW = 24;
   localparam logic [SqW-1:0] SqMax = {SqW{1'b1}};

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_DISCARD = 2'd1,
      CMD_STATUS = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_EMPTY = 2'd2,
      ST_SPARE = 2'd3
   } status_type;

   typedef logic [PtrW-1:0] ptr_type;

   function automatic ptr_type ptr_next(input ptr_type i);
      return (32'(i) + 1 >= Blocks) ? '0 : ptr_type'(32'(i) + 1);
   endfunction

   function automatic ptr_type ptr_prev(input ptr_type i);
      return (i == '0) ? ptr_type'(Blocks - 1) : ptr_type'(32'(i) - 1);
   endfunction

   function automatic logic [SqW-1:0] sat_add(input logic [SqW-1:0] a,
                                              input logic [SqW-1:0] b);
      logic [SqW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SqW] ? SqMax : s[SqW-1:0];
   endfunction

endpackage

// ----- rtl/lookahead_junction_speed_planner.sv -----
// A discard, status or full-ring push word passes S_ORD, S_OWAIT, S_OTAIL and S_OEXIT
// to S_OUT, where rsp_valid rises; other pushes pass S_MUL and S_WRITE first and, when
// replanning, a reverse pass (S_R0, S_R0W, S_RRD, S_RCALC) and a forward pass (S_FRD,
// S_FCALC, S_FW). One word at a time, each block memory having a single read port: the
// next word is taken in the idle cycle after the response leaves. Synchronous active-high
// reset clears the tail, head and plan pointers, the previous speed and control state;
// block memories are not cleared and hold whatever is written. Planner: ring of motion
// blocks in three memories, read-modify-write sequencer. Depends on ljsp_pkg.
module lookahead_junction_speed_planner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [ljsp_pkg::SpdW-1:0]     req_nominal_speed,
   input  logic [ljsp_pkg::SqW-1:0]      req_junction_limit_sq,
   input  logic [ljsp_pkg::SpdW-1:0]     req_accel,
   input  logic [ljsp_pkg::SpdW-1:0]     req_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [ljsp_pkg::SqW-1:0]      rsp_tail_entry_sq,
   output logic [ljsp_pkg::SqW-1:0]      rsp_exit_sq,
   output logic [3:0]                    rsp_count,
   output logic                          rsp_full_res,
   output logic                          rsp_tail_replanned
);
   import ljsp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_WRITE, S_R0, S_R0W, S_RRD, S_RCALC,
      S_FRD, S_FCALC, S_FW, S_ORD, S_OWAIT, S_OTAIL, S_OEXIT, S_OUT
   } state_type;

   // block memories
   logic [SqW-1:0] entry_mem [Blocks];
   logic [SqW-1:0] max_mem [Blocks];
   logic [SqW-1:0] ad_mem [Blocks];

   state_type state_ff;
   ptr_type tail_ff, head_ff, plan_ff, idx_ff, cur_ff;
   logic [SpdW-1:0] prev_ff;
   logic [SqW-1:0] nxe_ff, cure_ff;   // carried entry values
   logic [SqW-1:0] jlim_ff, mx_ff, ad_ff;
   logic [SpdW-1:0] smin_ff;
   logic [SpdW-1:0] acc_ff, len_ff;
   logic hit_ff;
   logic [1:0] status_ff;
   logic [SqW-1:0] tail_e_ff, exit_e_ff;
   logic [PtrW:0] cnt_ff;

   // one read port per memory, registered data
   ptr_type rd_addr;
   logic [SqW-1:0] rd_e, rd_m, rd_a;
   logic wr_en;
   ptr_type wr_addr;
   logic [SqW-1:0] wr_e;

   // squares and products of the pushed block, limit applied to the square
   logic [2*SpdW-1:0] sq_prod, ad_prod;
   logic [SqW-1:0] mx_lim;
   assign sq_prod = (2*SpdW)'(smin_ff) * (2*SpdW)'(smin_ff);
   assign ad_prod = (2*SpdW)'(acc_ff) * (2*SpdW)'(len_ff);
   assign mx_lim = (mx_ff > jlim_ff) ? jlim_ff : mx_ff;

   always_ff @(posedge clock) begin
      rd_e <= entry_mem[rd_addr];
      rd_m <= max_mem[rd_addr];
      rd_a <= ad_mem[rd_addr];
      if (wr_en) entry_mem[wr_addr] <= wr_e;
      if (state_ff == S_WRITE) begin
         max_mem[head_ff] <= mx_lim;
         ad_mem[head_ff] <= ad_ff;
      end
   end

   logic [PtrW:0] cnt_now;
   logic [SqW-1:0] rev_val, fwd_add;
   always_comb begin
      cnt_now = (head_ff >= tail_ff) ? (PtrW+1)'(head_ff) - (PtrW+1)'(tail_ff)
                : (PtrW+1)'(Blocks) - ((PtrW+1)'(tail_ff) - (PtrW+1)'(head_ff));
      rev_val = sat_add(nxe_ff, rd_a);
      if (rev_val > rd_m) rev_val = rd_m;
      fwd_add = sat_add(cure_ff, ad_ff);
      rd_addr = idx_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_e = nxe_ff;
      case (state_ff)
         S_WRITE: begin wr_en = 1'b1; wr_addr = head_ff; wr_e = '0; end
         S_R0W: begin wr_en = 1'b1; wr_e = nxe_ff; end
         S_RCALC: begin wr_en = (rd_e != rd_m); wr_e = rev_val; end
         S_FW: begin wr_en = 1'b1; wr_e = nxe_ff; end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = status_ff;
   assign rsp_tail_entry_sq = tail_e_ff;
   assign rsp_exit_sq = exit_e_ff;
   assign rsp_count = 4'(cnt_ff);
   assign rsp_full_res = (ptr_next(head_ff) == tail_ff);
   assign rsp_tail_replanned = hit_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tail_ff <= '0;
         head_ff <= '0;
         plan_ff <= '0;
         prev_ff <= '0;
         hit_ff <= 1'b0;
         status_ff <= ST_DONE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               hit_ff <= 1'b0;
               case (req_cmd)
                  CMD_PUSH: begin
                     if (ptr_next(head_ff) == tail_ff) begin
                        status_ff <= ST_FULL;
                        state_ff <= S_ORD;
                     end else begin
                        status_ff <= ST_DONE;
                        jlim_ff <= (head_ff == tail_ff) ? '0 : req_junction_limit_sq;
                        smin_ff <= (req_nominal_speed > prev_ff) ? prev_ff
                                   : req_nominal_speed;
                        acc_ff <= req_accel;
                        len_ff <= req_length;
                        prev_ff <= req_nominal_speed;
                        state_ff <= S_MUL;
                     end
                  end
                  CMD_DISCARD: begin
                     if (head_ff == tail_ff) status_ff <= ST_EMPTY;
                     else begin
                        status_ff <= ST_DONE;
                        if (tail_ff == plan_ff) plan_ff <= ptr_next(tail_ff);
                        tail_ff <= ptr_next(tail_ff);
                     end
                     state_ff <= S_ORD;
                  end
                  default: begin
                     status_ff <= ST_DONE;
                     state_ff <= S_ORD;
                  end
               endcase
            end
            S_MUL: begin
               mx_ff <= {8'd0, sq_prod};
               ad_ff <= {7'd0, ad_prod, 1'b0};
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               mx_ff <= mx_lim;
               head_ff <= ptr_next(head_ff);
               idx_ff <= head_ff;
               state_ff <= (head_ff == plan_ff) ? S_ORD : S_R0;
            end
            S_R0: begin
               // newest block ends at rest
               nxe_ff <= (mx_ff < ad_ff) ? mx_ff : ad_ff;
               state_ff <= S_R0W;
            end
            S_R0W: begin
               if (ptr_prev(idx_ff) == plan_ff) begin
                  hit_ff <= (ptr_prev(idx_ff) == tail_ff);
                  idx_ff <= plan_ff;
                  state_ff <= S_FRD;
               end else begin
                  idx_ff <= ptr_prev(idx_ff);
                  state_ff <= S_RRD;
               end
            end
            S_RRD: begin
               if (ptr_prev(idx_ff) == tail_ff) hit_ff <= 1'b1;
               state_ff <= S_RCALC;
            end
            S_RCALC: begin
               nxe_ff <= (rd_e != rd_m) ? rev_val : rd_e;
               if (ptr_prev(idx_ff) == plan_ff) begin
                  idx_ff <= plan_ff;
                  state_ff <= S_FRD;
               end else begin
                  idx_ff <= ptr_prev(idx_ff);
                  state_ff <= S_RRD;
               end
            end
            S_FRD: begin
               // read cur entry first, then next
               if (idx_ff == plan_ff) cur_ff <= plan_ff;
               state_ff <= S_FCALC;
            end
            S_FCALC: begin
               if (idx_ff == cur_ff) begin
                  // loaded current block
                  cure_ff <= rd_e;
                  ad_ff <= rd_a;
                  idx_ff <= ptr_next(cur_ff);
                  if (ptr_next(cur_ff) == head_ff) state_ff <= S_ORD;
                  else state_ff <= S_FRD;
               end else begin
                  nxe_ff <= (cure_ff < rd_e && fwd_add < rd_e) ? fwd_add : rd_e;
                  if ((cure_ff < rd_e && fwd_add < rd_e) || rd_e == rd_m)
                     plan_ff <= idx_ff;
                  state_ff <= S_FW;
               end
            end
            S_FW: begin
               // carry the updated block forward as current
               cure_ff <= nxe_ff;
               ad_ff <= rd_a;
               cur_ff <= idx_ff;
               idx_ff <= ptr_next(idx_ff);
               state_ff <= (ptr_next(idx_ff) == head_ff) ? S_ORD : S_FRD;
            end
            S_ORD: begin
               cnt_ff <= cnt_now;
               idx_ff <= tail_ff;
               state_ff <= S_OWAIT;
            end
            S_OWAIT: begin
               idx_ff <= ptr_next(tail_ff);
               state_ff <= S_OTAIL;
            end
            S_OTAIL: begin
               // tail entry lands now
               tail_e_ff <= (cnt_ff != '0) ? rd_e : '0;
               state_ff <= S_OEXIT;
            end
            S_OEXIT: begin
               // entry after the tail lands now
               exit_e_ff <= (cnt_ff >= (PtrW+1)'(2)) ? rd_e : '0;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- verif/lookahead_junction_speed_planner_test.sv -----
// Self-checking testbench for the look-ahead junction speed planner.
// Drives push, discard, status and spare words, predicts every response, checks all fields.
// Depends on ljsp_pkg and lookahead_junction_speed_planner.
`timescale 1ns / 100ps

module lookahead_junction_speed_planner_test;
   import ljsp_pkg::*;

   typedef struct packed {
      logic [1:0]      status;
      logic [SqW-1:0]  tail_entry_sq;
      logic [SqW-1:0]  exit_sq;
      logic [3:0]      count;
      logic            full_res;
      logic            tail_replanned;
   } plan_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = CMD_STATUS;
   logic [SpdW-1:0] req_nominal_speed = '0;
   logic [SqW-1:0] req_junction_limit_sq = '0;
   logic [SpdW-1:0] req_accel = '0;
   logic [SpdW-1:0] req_length = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [SqW-1:0] rsp_tail_entry_sq;
   logic [SqW-1:0] rsp_exit_sq;
   logic [3:0] rsp_count;
   logic rsp_full_res;
   logic rsp_tail_replanned;

   lookahead_junction_speed_planner uut (.*);

   always #5 clock = ~clock;

   // Planner shadow state
   logic [SqW-1:0] entry_sq [Blocks];
   logic [SqW-1:0] max_entry_sq [Blocks];
   logic [SqW-1:0] accel_dist [Blocks];
   ptr_type tail_p, head_p, planned_p;
   logic [SpdW-1:0] last_speed;

   plan_rsp_type expected_rsps [$];
   int mismatches = 0;
   int stall_mode = 0;

   function automatic ptr_type step_fwd(ptr_type i);
      return (32'(i) + 1 >= Blocks) ? '0 : ptr_type'(32'(i) + 1);
   endfunction

   function automatic ptr_type step_back(ptr_type i);
      return (i == '0) ? ptr_type'(Blocks - 1) : ptr_type'(32'(i) - 1);
   endfunction

   function automatic logic [SqW-1:0] clamp_sum(logic [SqW-1:0] a, logic [SqW-1:0] b);
      logic [SqW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SqW] ? {SqW{1'b1}} : s[SqW-1:0];
   endfunction

   function automatic logic [SqW-1:0] min_sq(logic [SqW-1:0] a, logic [SqW-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // Reverse then forward pass; report whether the reverse pass reached the tail
   function automatic logic replan_ring();
      logic hit;
      ptr_type idx, cur, nx;
      logic [SqW-1:0] e;
      hit = 1'b0;
      idx = step_back(head_p);
      if (idx == planned_p) return 1'b0;
      cur = idx;
      entry_sq[cur] = min_sq(max_entry_sq[cur], accel_dist[cur]);
      idx = step_back(idx);
      if (idx == planned_p) begin
         if (idx == tail_p) hit = 1'b1;
      end else begin
         while (idx != planned_p) begin
            nx = cur;
            cur = idx;
            idx = step_back(idx);
            if (idx == tail_p) hit = 1'b1;
            if (entry_sq[cur] != max_entry_sq[cur]) begin
               e = clamp_sum(entry_sq[nx], accel_dist[cur]);
               entry_sq[cur] = min_sq(e, max_entry_sq[cur]);
            end
         end
      end
      nx = planned_p;
      idx = step_fwd(planned_p);
      while (idx != head_p) begin
         cur = nx;
         nx = idx;
         if (entry_sq[cur] < entry_sq[nx]) begin
            e = clamp_sum(entry_sq[cur], accel_dist[cur]);
            if (e < entry_sq[nx]) begin
               entry_sq[nx] = e;
               planned_p = idx;
            end
         end
         if (entry_sq[nx] == max_entry_sq[nx]) planned_p = idx;
         idx = step_fwd(idx);
      end
      return hit;
   endfunction

   function automatic plan_rsp_type predict_plan(logic [1:0] cmd, logic [SpdW-1:0] nom,
         logic [SqW-1:0] jlim, logic [SpdW-1:0] acc, logic [SpdW-1:0] len);
      plan_rsp_type r;
      logic [SpdW-1:0] s;
      logic [SqW-1:0] mx, lim;
      logic [47:0] sq;
      int cnt;
      r = '0;
      r.status = ST_DONE;
      if (cmd == CMD_PUSH) begin
         if (step_fwd(head_p) == tail_p) begin
            r.status = ST_FULL;
         end else begin
            lim = (head_p == tail_p) ? '0 : jlim;
            s = (nom > last_speed) ? last_speed : nom;
            sq = 48'(s) * 48'(s);
            mx = SqW'(sq);
            if (mx > lim) mx = lim;
            entry_sq[head_p] = '0;
            max_entry_sq[head_p] = mx;
            accel_dist[head_p] = SqW'(2 * 64'(acc) * 64'(len));
            last_speed = nom;
            head_p = step_fwd(head_p);
            r.tail_replanned = replan_ring();
         end
      end else if (cmd == CMD_DISCARD) begin
         if (head_p == tail_p) begin
            r.status = ST_EMPTY;
         end else begin
            if (tail_p == planned_p) planned_p = step_fwd(tail_p);
            tail_p = step_fwd(tail_p);
         end
      end
      cnt = (head_p >= tail_p) ? head_p - tail_p : Blocks - (tail_p - head_p);
      r.tail_entry_sq = (cnt >= 1) ? entry_sq[tail_p] : '0;
      r.exit_sq = (cnt >= 2) ? entry_sq[step_fwd(tail_p)] : '0;
      r.count = 4'(cnt);
      r.full_res = (step_fwd(head_p) == tail_p);
      return r;
   endfunction

   int burst_left = 0;

   // Send one word, with bursts and random gaps between them; valid stays up inside a burst
   task automatic send_word(logic [1:0] cmd, logic [SpdW-1:0] nom, logic [SqW-1:0] jlim,
         logic [SpdW-1:0] acc, logic [SpdW-1:0] len);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      expected_rsps.push_back(predict_plan(cmd, nom, jlim, acc, len));
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_nominal_speed <= nom;
      req_junction_limit_sq <= jlim;
      req_accel <= acc;
      req_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [SqW-1:0] rand_sq();
      logic [SqW-1:0] v;
      v = SqW'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: return {SqW{1'b1}};
         1: return v >> $urandom_range(0, SqW - 1);
         default: return v;
      endcase
   endfunction

   function automatic logic [SpdW-1:0] rand_spd();
      logic [SpdW-1:0] v;
      v = SpdW'($urandom);
      return ($urandom_range(0, 3) == 0) ? v : v >> $urandom_range(0, SpdW - 1);
   endfunction

   task automatic push_random();
      send_word(CMD_PUSH, rand_spd(), rand_sq(), rand_spd(), rand_spd());
   endtask

   // Extremes, every command, full and empty ring cases
   task automatic test_directed();
      send_word(CMD_DISCARD, '0, '0, '0, '0);
      send_word(CMD_STATUS, '0, '0, '0, '0);
      send_word(CMD_SPARE, '1, '1, '1, '1);
      send_word(CMD_PUSH, '1, '1, '1, '1);
      send_word(CMD_PUSH, '1, '1, '1, '1);
      send_word(CMD_PUSH, '0, '1, '0, '0);
      send_word(CMD_PUSH, 24'h1000, 56'h0, 24'h10, 24'h100);
      for (int i = 0; i < 13; i++)
         send_word(CMD_PUSH, 24'h800 + 24'(i * 37), '1, 24'h100, 24'h400);
      send_word(CMD_PUSH, '1, '1, '1, '1);
      send_word(CMD_STATUS, '0, '0, '0, '0);
      repeat (16) send_word(CMD_DISCARD, '1, '1, '1, '1);
   endtask

   // Mostly pushes and discards in runs that sweep the ring from empty to full
   task automatic test_random_traffic();
      int push_bias;
      for (int n = 0; n < 1425; n++) begin
         if (n % 60 == 0) begin
            push_bias = $urandom_range(20, 80);
            stall_mode = $urandom_range(0, 3);
         end
         if ($urandom_range(0, 99) < 8)
            send_word(2'($urandom_range(2, 3)), rand_spd(), rand_sq(), rand_spd(),
                      rand_spd());
         else if ($urandom_range(0, 99) < push_bias)
            push_random();
         else
            send_word(CMD_DISCARD, rand_spd(), rand_sq(), rand_spd(), rand_spd());
      end
   endtask

   // Receiver stall pattern: off, light, heavy or periodic
   int stall_tick = 0;
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= (stall_tick % 7) < 3;
      endcase
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      plan_rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_tail_entry_sq, rsp_exit_sq, rsp_count, rsp_full_res,
                 rsp_tail_replanned};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < Blocks; i++) begin
         entry_sq[i] = '0;
         max_entry_sq[i] = '0;
         accel_dist[i] = '0;
      end
      tail_p = '0;
      head_p = '0;
      planned_p = '0;
      last_speed = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("lookahead_junction_speed_planner_test: PASS");
      else
         $display("lookahead_junction_speed_planner_test: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("lookahead_junction_speed_planner_test: FAIL");
      $finish;
   end

endmodule
